// ===== hw/rtl/ffcfl_pkg.sv =====
// Shared types and codes for the first-fit coalescing free list.
package ffcfl_pkg;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [1:0] ST_ALLOC_OK   = 2'd0;
   localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
   localparam logic [1:0] ST_FREED      = 2'd2;
   localparam logic [1:0] ST_LOST       = 2'd3;

   typedef struct packed {
      logic        kind;
      logic [31:0] addr;
      logic [31:0] size;
   } op_type;

   // Outcome of the search, common to every cell.
   typedef struct packed {
      logic found;
      logic rm;
      logic mp;
      logic mn;
      logic full;
   } dec_type;

   // Position of one cell relative to the search result.
   typedef struct packed {
      logic valid;
      logic pre;
      logic first;
      logic ge;
      logic is_pos;
      logic is_prev;
   } sel_type;

   typedef struct packed {
      logic hit;
      logic rm;
      logic mp;
      logic mn;
   } flag_type;

endpackage

// ===== hw/rtl/ffcfl_req_if.sv =====
// Request channel: valid/ready handshake with operation, address and size.
interface ffcfl_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] addr;
   logic [31:0] size;

   modport source (output valid, kind, addr, size, input ready);
   modport sink   (input valid, kind, addr, size, output ready);
endinterface

// ===== hw/rtl/ffcfl_rsp_if.sv =====
// Response channel: valid/ready handshake with status and table statistics.
interface ffcfl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] alloc_addr;
   logic [31:0] free_total;
   logic [8:0]  entry_count;
   logic [8:0]  peak_count;
   logic [31:0] lost_count;
   logic [31:0] lost_bytes;

   modport source (output valid, status, alloc_addr, free_total, entry_count, peak_count,
                   lost_count, lost_bytes, input ready);
   modport sink   (input valid, status, alloc_addr, free_total, entry_count, peak_count,
                   lost_count, lost_bytes, output ready);
endinterface

// ===== hw/rtl/ffcfl_cell.sv =====
// One table cell: holds a single free region and shifts with its neighbours.
module ffcfl_cell
   import ffcfl_pkg::*;
(
   input  logic        clock,
   input  op_type      op_i,
   input  sel_type     sel_i,
   input  dec_type     dec_i,
   input  logic        apply_i,
   input  logic [31:0] prev_start_i,
   input  logic [31:0] prev_len_i,
   input  logic [31:0] next_start_i,
   input  logic [31:0] next_len_i,
   output logic [31:0] start_o,
   output logic [31:0] len_o,
   output flag_type    flag_o,
   output logic [31:0] grant_o
);

   logic [31:0] start_ff, start_in;
   logic [31:0] len_ff, len_in;

   always_comb begin
      flag_o.hit = sel_i.valid & ((op_i.kind == KIND_ALLOC) ? (len_ff >= op_i.size)
                                                             : (start_ff > op_i.addr));
      flag_o.rm  = sel_i.first & (len_ff == op_i.size);
      flag_o.mp  = sel_i.is_prev & ((start_ff + len_ff) == op_i.addr);
      flag_o.mn  = sel_i.is_pos & sel_i.valid & ((op_i.addr + op_i.size) == start_ff);
      grant_o    = sel_i.first ? start_ff : 32'd0;
   end

   always_comb begin
      start_in = start_ff;
      len_in   = len_ff;
      if (op_i.kind == KIND_ALLOC) begin
         if (dec_i.found) begin
            if (dec_i.rm && sel_i.ge) begin
               start_in = next_start_i;
               len_in   = next_len_i;
            end else if (sel_i.first) begin
               start_in = start_ff + op_i.size;
               len_in   = len_ff - op_i.size;
            end
         end
      end else if (dec_i.mp) begin
         if (sel_i.is_prev) begin
            len_in = len_ff + op_i.size + (dec_i.mn ? next_len_i : 32'd0);
         end else if (dec_i.mn && sel_i.ge) begin
            start_in = next_start_i;
            len_in   = next_len_i;
         end
      end else if (dec_i.mn) begin
         if (sel_i.is_pos) begin
            start_in = op_i.addr;
            len_in   = len_ff + op_i.size;
         end
      end else if (!dec_i.full) begin
         if (sel_i.is_pos) begin
            start_in = op_i.addr;
            len_in   = op_i.size;
         end else if (sel_i.ge) begin
            start_in = prev_start_i;
            len_in   = prev_len_i;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (apply_i) begin
         start_ff <= start_in;
         len_ff   <= len_in;
      end
   end

   assign start_o = start_ff;
   assign len_o   = len_ff;

endmodule

// ===== hw/rtl/first_fit_coalescing_free_list_unit.sv =====
// First-fit free list with coalescing, built as a row of region cells kept sorted by address.
// Each word passes through these steps from acceptance to response: one compare step across all
// cells, a registered prefix-OR scan of clog2(TABLE_ENTRIES) levels that locates the
// first fit or the insertion point, a step that gathers merge flags, and a step in which
// every cell shifts or updates at once while the response register loads. One word is in
// flight at a time, and the next word is taken only once the response has been accepted.
// Reset empties the table at once.
module first_fit_coalescing_free_list_unit
   import ffcfl_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256
)(
   input  logic        clock,
   input  logic        reset,
   ffcfl_req_if.sink   req,
   ffcfl_rsp_if.source rsp
);

   localparam int N   = TABLE_ENTRIES;
   localparam int CW  = $clog2(N + 1);
   localparam int LV  = $clog2(N);
   localparam int LVB = $clog2(LV + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CMP   = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_FLAG  = 3'd3;
   localparam logic [2:0] S_APPLY = 3'd4;

   logic [2:0]     state_ff, state_in;
   op_type         op_ff;
   logic [N-1:0]   pre_ff, pre_in;
   logic [LVB-1:0] lvl_ff;
   dec_type        dec_ff, dec_in;
   logic [31:0]    grant_ff, grant_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  peak_ff;
   logic [31:0]    total_ff, total_in;
   logic [31:0]    lost_cnt_ff, lost_bytes_ff;
   logic           rsp_valid_ff;
   logic [1:0]     status_ff, status_in;
   logic [31:0]    alloc_addr_ff;
   logic           lost;

   logic [31:0]    start_w [N];
   logic [31:0]    len_w   [N];
   flag_type       flag_w  [N];
   logic [31:0]    cgrant_w [N];
   sel_type        sel_w   [N];
   logic [N-1:0]   valid_v, b_v;
   logic [N:0]     pos_v;
   logic [N-1:0]   hit_v;
   logic           accept;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;

   // Release position: the first held region starting above the address, else the count.
   always_comb begin
      for (int j = 0; j < N; j++) begin
         valid_v[j] = (CW'(j) < count_ff);
         b_v[j]     = valid_v[j] & pre_ff[j];
      end
      for (int j = 0; j <= N; j++) begin
         pos_v[j] = ((j == 0) ? 1'b1 : !b_v[(j == 0) ? 0 : j - 1]) &
                    (((j < N) ? b_v[(j < N) ? j : 0] : 1'b0) | (count_ff == CW'(j)));
      end
      for (int j = 0; j < N; j++) begin
         sel_w[j].valid   = valid_v[j];
         sel_w[j].pre     = pre_ff[j];
         sel_w[j].first   = (op_ff.kind == KIND_ALLOC) &
                            pre_ff[j] & !((j > 0) && pre_ff[(j > 0) ? j - 1 : 0]);
         sel_w[j].ge      = (op_ff.kind == KIND_ALLOC) ? pre_ff[j] : (b_v[j] | !valid_v[j]);
         sel_w[j].is_pos  = pos_v[j];
         sel_w[j].is_prev = pos_v[j + 1];
      end
   end

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         logic [31:0] ps, pl, ns, nl;
         if (g == 0) begin : g_first
            assign ps = 32'd0;
            assign pl = 32'd0;
         end else begin : g_mid
            assign ps = start_w[g-1];
            assign pl = len_w[g-1];
         end
         if (g == N - 1) begin : g_last
            assign ns = 32'd0;
            assign nl = 32'd0;
         end else begin : g_inner
            assign ns = start_w[g+1];
            assign nl = len_w[g+1];
         end
         ffcfl_cell u_cell (
            .clock        (clock),
            .op_i         (op_ff),
            .sel_i        (sel_w[g]),
            .dec_i        (dec_ff),
            .apply_i      (state_ff == S_APPLY),
            .prev_start_i (ps),
            .prev_len_i   (pl),
            .next_start_i (ns),
            .next_len_i   (nl),
            .start_o      (start_w[g]),
            .len_o        (len_w[g]),
            .flag_o       (flag_w[g]),
            .grant_o      (cgrant_w[g])
         );
      end
   endgenerate

   always_comb begin
      dec_in   = '0;
      grant_in = 32'd0;
      for (int j = 0; j < N; j++) begin
         hit_v[j]  = flag_w[j].hit;
         dec_in.rm = dec_in.rm | flag_w[j].rm;
         dec_in.mp = dec_in.mp | flag_w[j].mp;
         dec_in.mn = dec_in.mn | flag_w[j].mn;
         grant_in  = grant_in | cgrant_w[j];
      end
      dec_in.found = pre_ff[N-1];
      dec_in.full  = (count_ff == CW'(N));
   end

   assign lost = (op_ff.kind == KIND_FREE) && !dec_ff.mp && !dec_ff.mn && dec_ff.full;

   always_comb begin
      count_in  = count_ff;
      total_in  = total_ff;
      status_in = ST_FREED;
      if (op_ff.kind == KIND_ALLOC) begin
         if (dec_ff.found) begin
            status_in = ST_ALLOC_OK;
            total_in  = total_ff - op_ff.size;
            if (dec_ff.rm) begin
               count_in = count_ff - CW'(1);
            end
         end else begin
            status_in = ST_ALLOC_FAIL;
         end
      end else if (lost) begin
         status_in = ST_LOST;
      end else begin
         total_in = total_ff + op_ff.size;
         if (dec_ff.mp && dec_ff.mn) begin
            count_in = count_ff - CW'(1);
         end else if (!dec_ff.mp && !dec_ff.mn) begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      pre_in   = pre_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            pre_in   = hit_v;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            pre_in = pre_ff | (pre_ff << (1 << lvl_ff));
            if (lvl_ff == LVB'(LV - 1)) begin
               state_in = S_FLAG;
            end
         end
         S_FLAG:  state_in = S_APPLY;
         S_APPLY: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         peak_ff       <= '0;
         total_ff      <= 32'd0;
         lost_cnt_ff   <= 32'd0;
         lost_bytes_ff <= 32'd0;
         rsp_valid_ff  <= 1'b0;
         lvl_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == S_CMP) begin
            lvl_ff <= '0;
         end else if (state_ff == S_SCAN) begin
            lvl_ff <= lvl_ff + LVB'(1);
         end
         if (state_ff == S_APPLY) begin
            count_ff     <= count_in;
            total_ff     <= total_in;
            rsp_valid_ff <= 1'b1;
            if (count_in > peak_ff) begin
               peak_ff <= count_in;
            end
            if (lost) begin
               lost_cnt_ff   <= lost_cnt_ff + 32'd1;
               lost_bytes_ff <= lost_bytes_ff + op_ff.size;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pre_ff <= pre_in;
      if (accept) begin
         op_ff.kind <= req.kind;
         op_ff.addr <= req.addr;
         op_ff.size <= req.size;
      end
      if (state_ff == S_FLAG) begin
         dec_ff   <= dec_in;
         grant_ff <= grant_in;
      end
      if (state_ff == S_APPLY) begin
         status_ff     <= status_in;
         alloc_addr_ff <= (status_in == ST_ALLOC_OK) ? grant_ff : 32'd0;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.alloc_addr  = alloc_addr_ff;
   assign rsp.free_total  = total_ff;
   assign rsp.entry_count = 9'(count_ff);
   assign rsp.peak_count  = 9'(peak_ff);
   assign rsp.lost_count  = lost_cnt_ff;
   assign rsp.lost_bytes  = lost_bytes_ff;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the first-fit coalescing free list unit.
module tb;
   import ffcfl_pkg::*;

   localparam int DEPTH     = 256;
   localparam int LIMIT     = 900000;
   localparam int N_RANDOM  = 1380;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ffcfl_req_if req();
   ffcfl_rsp_if rsp();

   first_fit_coalescing_free_list_unit #(.TABLE_ENTRIES(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] alloc_addr;
      logic [31:0] free_total;
      logic [8:0]  entry_count;
      logic [8:0]  peak_count;
      logic [31:0] lost_count;
      logic [31:0] lost_bytes;
   } outcome_t;

   typedef struct {
      logic        kind;
      logic [31:0] addr;
      logic [31:0] size;
      logic        known;
      outcome_t    want;
   } row_t;

   // Mirror of the free region table.
   logic [31:0] fl_start [DEPTH];
   logic [31:0] fl_len   [DEPTH];
   int          fl_count;
   int          fl_peak;
   logic [31:0] fl_lost;
   logic [31:0] fl_lost_bytes;

   outcome_t expected_q [$];
   outcome_t typed_q    [$];
   logic     typed_flag [$];
   int       errors;
   int       cycles;
   logic     sending_done;
   int       idle_pct_src;
   int       idle_pct_snk;
   int       hold_off;

   function automatic void drop_region(int pos);
      fl_count--;
      for (int j = pos; j < fl_count; j++) begin
         fl_start[j] = fl_start[j+1];
         fl_len[j]   = fl_len[j+1];
      end
   endfunction

   function automatic outcome_t predict_region_op(logic kind, logic [31:0] addr,
                                                   logic [31:0] size);
      outcome_t    o;
      int          i;
      logic [31:0] fin;
      logic        done;
      o = '0;
      done = 1'b0;
      if (kind == KIND_ALLOC) begin
         o.status = ST_ALLOC_FAIL;
         for (i = 0; i < fl_count && !done; i++) begin
            if (fl_len[i] >= size) begin
               o.status     = ST_ALLOC_OK;
               o.alloc_addr = fl_start[i];
               fl_start[i]  = fl_start[i] + size;
               fl_len[i]    = fl_len[i] - size;
               if (fl_len[i] == 32'd0) drop_region(i);
               done = 1'b1;
            end
         end
      end else begin
         fin = addr + size;
         o.status = ST_FREED;
         i = 0;
         while (i < fl_count && fl_start[i] <= addr) i++;
         if (i > 0 && fl_start[i-1] + fl_len[i-1] == addr) begin
            fl_len[i-1] = fl_len[i-1] + size;
            if (i < fl_count && fin == fl_start[i]) begin
               fl_len[i-1] = fl_len[i-1] + fl_len[i];
               drop_region(i);
            end
         end else if (i < fl_count && fin == fl_start[i]) begin
            fl_start[i] = addr;
            fl_len[i]   = fl_len[i] + size;
         end else if (fl_count < DEPTH) begin
            for (int j = fl_count; j > i; j--) begin
               fl_start[j] = fl_start[j-1];
               fl_len[j]   = fl_len[j-1];
            end
            fl_count++;
            if (fl_peak < fl_count) fl_peak = fl_count;
            fl_start[i] = addr;
            fl_len[i]   = size;
         end else begin
            fl_lost       = fl_lost + 32'd1;
            fl_lost_bytes = fl_lost_bytes + size;
            o.status      = ST_LOST;
         end
      end
      for (int k = 0; k < fl_count; k++) o.free_total = o.free_total + fl_len[k];
      o.entry_count = fl_count[8:0];
      o.peak_count  = fl_peak[8:0];
      o.lost_count  = fl_lost;
      o.lost_bytes  = fl_lost_bytes;
      return o;
   endfunction

   // The word stays offered from one call to the next unless the sender idles.
   task automatic send_word(logic kind, logic [31:0] addr, logic [31:0] size,
                            logic known, outcome_t want);
      outcome_t pred;
      while ($urandom_range(99) < idle_pct_src) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.kind  <= kind;
      req.addr  <= addr;
      req.size  <= size;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      pred = predict_region_op(kind, addr, size);
      expected_q.push_back(pred);
      typed_q.push_back(want);
      typed_flag.push_back(known);
   endtask

   task automatic send_random(logic kind, logic [31:0] addr, logic [31:0] size);
      send_word(kind, addr, size, 1'b0, '0);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // Random address and size: mostly small values in a narrow window, so
   // that releases merge and allocations fit; sometimes full-width values.
   function automatic logic [31:0] pick_value(int span);
      case ($urandom_range(9))
         0:       return $urandom();
         1:       return 32'hFFFF_FFFF - $urandom_range(16);
         default: return $urandom_range(span);
      endcase
   endfunction

   // Response side: ready with random stalls, plus a long hold-off on demand.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off  <= hold_off - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= idle_pct_snk);
      end
   end

   always @(posedge clock) begin
      outcome_t got;
      outcome_t want;
      outcome_t typed;
      logic     has_typed;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.status, rsp.alloc_addr, rsp.free_total, rsp.entry_count,
                 rsp.peak_count, rsp.lost_count, rsp.lost_bytes};
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected word %h", $time, got);
            errors++;
         end else begin
            want      = expected_q.pop_front();
            typed     = typed_q.pop_front();
            has_typed = typed_flag.pop_front();
            if (has_typed && typed != want) begin
               $display("%0t: table row disagrees, expected %h predicted %h",
                        $time, typed, want);
               errors++;
            end
            if (got.status != want.status)
               $display("%0t: status expected %h actual %h", $time,
                        want.status, got.status);
            if (got.alloc_addr != want.alloc_addr)
               $display("%0t: alloc_addr expected %h actual %h", $time,
                        want.alloc_addr, got.alloc_addr);
            if (got.free_total != want.free_total)
               $display("%0t: free_total expected %h actual %h", $time,
                        want.free_total, got.free_total);
            if (got.entry_count != want.entry_count)
               $display("%0t: entry_count expected %0d actual %0d", $time,
                        want.entry_count, got.entry_count);
            if (got.peak_count != want.peak_count)
               $display("%0t: peak_count expected %0d actual %0d", $time,
                        want.peak_count, got.peak_count);
            if (got.lost_count != want.lost_count)
               $display("%0t: lost_count expected %h actual %h", $time,
                        want.lost_count, got.lost_count);
            if (got.lost_bytes != want.lost_bytes)
               $display("%0t: lost_bytes expected %h actual %h", $time,
                        want.lost_bytes, got.lost_bytes);
            if (got != want) errors++;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   row_t directed [] = '{
      '{KIND_ALLOC, 32'd0, 32'd0, 1'b1,
        '{ST_ALLOC_FAIL, 32'd0, 32'd0, 9'd0, 9'd0, 32'd0, 32'd0}},
      '{KIND_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        '{ST_ALLOC_FAIL, 32'd0, 32'd0, 9'd0, 9'd0, 32'd0, 32'd0}},
      '{KIND_FREE, 32'h0000_1000, 32'h100, 1'b1,
        '{ST_FREED, 32'd0, 32'h100, 9'd1, 9'd1, 32'd0, 32'd0}},
      '{KIND_FREE, 32'h0000_1100, 32'h100, 1'b0, '0},
      '{KIND_FREE, 32'h0000_0F00, 32'h100, 1'b0, '0},
      '{KIND_FREE, 32'h0000_2000, 32'h10, 1'b0, '0},
      '{KIND_FREE, 32'h0000_3000, 32'h10, 1'b0, '0},
      '{KIND_FREE, 32'h0000_2010, 32'hFF0, 1'b0, '0},
      '{KIND_ALLOC, 32'h0, 32'h0, 1'b0, '0},
      '{KIND_ALLOC, 32'h0, 32'h300, 1'b0, '0},
      '{KIND_ALLOC, 32'h0, 32'h1000, 1'b0, '0},
      '{KIND_ALLOC, 32'h0, 32'h20000, 1'b0, '0},
      '{KIND_FREE, 32'h0000_5000, 32'h0, 1'b0, '0},
      '{KIND_ALLOC, 32'h0, 32'h0, 1'b0, '0},
      '{KIND_FREE, 32'hFFFF_FFF0, 32'h20, 1'b0, '0},
      '{KIND_FREE, 32'h0000_0010, 32'h10, 1'b0, '0},
      '{KIND_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{KIND_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{KIND_ALLOC, 32'h0, 32'h1, 1'b0, '0},
      '{KIND_FREE, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
      '{KIND_ALLOC, 32'h0, 32'h7FFF_FFFF, 1'b0, '0}
   };

   initial begin
      logic [31:0] a;
      logic [31:0] s;
      int          burst;
      for (int k = 0; k < DEPTH; k++) begin
         fl_start[k] = '0;
         fl_len[k]   = '0;
      end
      fl_count = 0; fl_peak = 0; fl_lost = '0; fl_lost_bytes = '0;
      errors = 0; cycles = 0; hold_off = 0;
      idle_pct_src = 0; idle_pct_snk = 0;
      req.valid = 1'b0; req.kind = 1'b0; req.addr = '0; req.size = '0;
      rsp.ready = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[r])
         send_word(directed[r].kind, directed[r].addr, directed[r].size,
                   directed[r].known, directed[r].want);
      wait_drained();

      // Fill the table with scattered one-byte holes, overflow it, and let
      // the response side stall for a long stretch meanwhile.
      hold_off <= 400;
      for (int k = 0; k < DEPTH + 6; k++) send_random(KIND_FREE, 32'h4000_0000 + 4 * k, 32'd1);
      send_random(KIND_FREE, 32'h9000_0000, $urandom());
      send_random(KIND_FREE, 32'h4000_0001, 32'd3);
      for (int k = 0; k < 10; k++) send_random(KIND_ALLOC, 32'd0, 32'd1);
      wait_drained();

      for (int n = 0; n < N_RANDOM; n++) begin
         case ((n * 4) / N_RANDOM)
            0: begin idle_pct_src = 0;  idle_pct_snk = 0;  end
            1: begin idle_pct_src = 74; idle_pct_snk = 0;  end
            2: begin idle_pct_src = 0;  idle_pct_snk = 74; end
            default: begin idle_pct_src = 14; idle_pct_snk = 14; end
         endcase
         // Stretches without idling.
         if ($urandom_range(19) == 0) begin
            idle_pct_src = 0; idle_pct_snk = 0;
         end
         burst = $urandom_range(3);
         if ($urandom_range(1)) begin
            a = pick_value(4096);
            s = pick_value(64);
            send_random(KIND_FREE, a, s);
            // Often release the neighbouring block too, to force merges.
            if (burst == 0) send_random(KIND_FREE, a + s, pick_value(64));
         end else begin
            send_random(KIND_ALLOC, $urandom(), pick_value(96));
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
